### rtl/core/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types, opcodes, widths and the divider step for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  // number format
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 8;

  // divider geometry: dividend is |a| << FRAC_BITS, two quotient bits per stage
  localparam int unsigned DVD_W     = DATA_W + FRAC_BITS;
  localparam int unsigned DIV_STEPS = (DVD_W + 1) / 2;
  localparam int unsigned DVD_PAD   = 2 * DIV_STEPS;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // start-to-strobe latency: front reg, queue, back entry, divider, output reg
  localparam int unsigned ALU_LATENCY = DIV_STEPS + 4;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_LT       = 4'd6,
    OP_GT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_EQ       = 4'd10,
    OP_NE       = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALU = 2'd0,
    KIND_MUL = 2'd1,
    KIND_DIV = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0]               op;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     compare_true;
    logic                     divide_by_zero;
  } alu_rsp_t;

  // classified transaction handed from front to back
  typedef struct packed {
    alu_req_t req;
    kind_e    kind;
    logic     div_zero;
  } issue_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rem;
    logic [DVD_PAD-1:0] work;
  } div_step_t;

  // one restoring step: shift the next dividend bit out of work and a quotient bit into it
  function automatic div_step_t div_step(input logic [DATA_W-1:0]  rem,
                                         input logic [DVD_PAD-1:0] work,
                                         input logic [DATA_W-1:0]  dvs);
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    div_step_t       r;
    trial = {rem, work[DVD_PAD-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      r.rem  = diff[DATA_W-1:0];
      r.work = {work[DVD_PAD-2:0], 1'b1};
    end else begin
      r.rem  = trial[DATA_W-1:0];
      r.work = {work[DVD_PAD-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/core/fixed_point_q24_8_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Signed Q24.8 ALU: add, sub, mul, div, inc, dec, compares, min, max, integer conversions.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low, one per clock.
// Every result appears on rsp_o with valid_o high for one cycle, in order;
// the delay from its start comes from the 20-stage divider (two quotient
// bits per stage over the 40-bit dividend), which all operations pass beside
// so order is kept. Results cannot be held off, so the back end never stalls
// and busy_o stays low in practice.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  fxalu_pkg::alu_req_t req_i,
  output logic                valid_o,
  output fxalu_pkg::alu_rsp_t rsp_o
);
  import fxalu_pkg::*;

  issue_t front_issue;
  issue_t queue_issue;
  logic   push;
  logic   q_full;
  logic   q_valid;

  // front: handshake and classification
  fxalu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .issue_o  (front_issue)
  );

  // queue between front and back
  fxalu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_issue),
    .full_o  (q_full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (queue_issue)
  );

  // back: execution and result strobe
  fxalu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .issue_i    (queue_issue),
    .valid_o    (valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

### rtl/core/fxalu_front.sv
// ----------------------------------------------------------------------------
// fxalu_front
// Takes transactions on the start/busy handshake and classifies them.
// ----------------------------------------------------------------------------
module fxalu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  fxalu_pkg::alu_req_t req_i,
  input  logic               q_full_i,
  output logic               push_o,
  output fxalu_pkg::issue_t  issue_o
);
  import fxalu_pkg::*;

  logic     valid_q, valid_d;
  issue_t   issue_q, issue_d;
  logic     accept;

  // handshake
  assign push_o  = valid_q && !q_full_i;
  assign busy_o  = valid_q && q_full_i;
  assign accept  = start_i && !busy_o;
  assign issue_o = issue_q;

  // classify the incoming transaction
  always_comb begin
    issue_d.req      = req_i;
    issue_d.div_zero = 1'b0;
    case (op_e'(req_i.op))
      OP_MUL:  issue_d.kind = KIND_MUL;
      OP_DIV: begin
        issue_d.kind     = KIND_DIV;
        issue_d.div_zero = (req_i.operand_b == '0);
      end
      default: issue_d.kind = KIND_ALU;
    endcase
  end

  assign valid_d = accept || (valid_q && !push_o);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      issue_q <= issue_d;
    end
  end

endmodule

### rtl/core/fxalu_queue.sv
// ----------------------------------------------------------------------------
// fxalu_queue
// Small FIFO between the front and the back of the ALU.
// ----------------------------------------------------------------------------
module fxalu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fxalu_pkg::issue_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fxalu_pkg::issue_t data_o
);
  import fxalu_pkg::*;

  issue_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/fxalu_div.sv
// ----------------------------------------------------------------------------
// fxalu_div
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module fxalu_div (
  input  logic                            clk_i,
  input  logic [fxalu_pkg::DVD_PAD-1:0]   dvd_i,
  input  logic [fxalu_pkg::DATA_W-1:0]    dvs_i,
  input  logic                            neg_i,
  output logic [fxalu_pkg::DVD_PAD-1:0]   quo_o,
  output logic                            neg_o
);
  import fxalu_pkg::*;

  logic [DVD_PAD-1:0] work_q [DIV_STEPS+1];
  logic               neg_q  [DIV_STEPS+1];
  logic [DATA_W-1:0]  rem_q  [DIV_STEPS];
  logic [DATA_W-1:0]  dvs_q  [DIV_STEPS];

  // entry stage
  always_ff @(posedge clk_i) begin
    work_q[0] <= dvd_i;
    neg_q[0]  <= neg_i;
    rem_q[0]  <= '0;
    dvs_q[0]  <= dvs_i;
  end

  // iteration stages
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_stage
    div_step_t step_a, step_b;

    always_comb begin
      step_a = div_step(rem_q[k-1], work_q[k-1], dvs_q[k-1]);
      step_b = div_step(step_a.rem, step_a.work, dvs_q[k-1]);
    end

    always_ff @(posedge clk_i) begin
      work_q[k] <= step_b.work;
      neg_q[k]  <= neg_q[k-1];
    end

    if (k < DIV_STEPS) begin : g_keep
      always_ff @(posedge clk_i) begin
        rem_q[k] <= step_b.rem;
        dvs_q[k] <= dvs_q[k-1];
      end
    end
  end

  assign quo_o = work_q[DIV_STEPS];
  assign neg_o = neg_q[DIV_STEPS];

endmodule

### rtl/core/fxalu_back.sv
// ----------------------------------------------------------------------------
// fxalu_back
// Executes classified transactions and drives the result strobe.
// ----------------------------------------------------------------------------
module fxalu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fxalu_pkg::issue_t  issue_i,
  output logic               valid_o,
  output fxalu_pkg::alu_rsp_t rsp_o
);
  import fxalu_pkg::*;

  typedef struct packed {
    kind_e                    kind;
    logic                     div_zero;
    logic                     cmp;
    logic signed [DATA_W-1:0] res;
  } side_t;

  logic signed [DATA_W-1:0]   a, b;
  logic signed [DATA_W-1:0]   simple_res;
  logic                       simple_cmp;
  logic signed [2*DATA_W-1:0] prod_d, prod_q;
  logic [DATA_W-1:0]          abs_a, abs_b;
  logic [DVD_PAD-1:0]         dvd;
  logic                       s1_valid_q;
  side_t                      s1_q, side_d;
  logic [DIV_STEPS-1:0]       side_valid_q;
  side_t                      side_q [DIV_STEPS];
  logic [DVD_PAD-1:0]         quo;
  logic [DVD_PAD-1:0]         quo_signed;
  logic                       quo_neg;
  side_t                      last;
  alu_rsp_t                   rsp_d, rsp_q;
  logic                       valid_q;

  assign a = issue_i.req.operand_a;
  assign b = issue_i.req.operand_b;

  // combinational operations and comparisons
  always_comb begin
    simple_res = '0;
    simple_cmp = 1'b0;
    case (op_e'(issue_i.req.op))
      OP_ADD:      simple_res = a + b;
      OP_SUB:      simple_res = a - b;
      OP_INC:      simple_res = a + DATA_W'(1);
      OP_DEC:      simple_res = a - DATA_W'(1);
      OP_LT:       simple_cmp = (a < b);
      OP_GT:       simple_cmp = (a > b);
      OP_LE:       simple_cmp = (a <= b);
      OP_GE:       simple_cmp = (a >= b);
      OP_EQ:       simple_cmp = (a == b);
      OP_NE:       simple_cmp = (a != b);
      OP_MIN:      simple_res = (a < b) ? a : b;
      OP_MAX:      simple_res = (a > b) ? a : b;
      OP_TO_INT:   simple_res = a >>> FRAC_BITS;
      OP_FROM_INT: simple_res = a << FRAC_BITS;
      default:     simple_res = '0;
    endcase
  end

  // full product, shifted after the register
  assign prod_d = a * b;

  // divider operands as sign and magnitude
  assign abs_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign abs_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign dvd   = DVD_PAD'({abs_a, {FRAC_BITS{1'b0}}});

  fxalu_div u_div (
    .clk_i (clk_i),
    .dvd_i (dvd),
    .dvs_i (abs_b),
    .neg_i (a[DATA_W-1] ^ b[DATA_W-1]),
    .quo_o (quo),
    .neg_o (quo_neg)
  );

  // entry stage
  always_ff @(posedge clk_i) begin
    s1_q.kind     <= issue_i.kind;
    s1_q.div_zero <= issue_i.div_zero;
    s1_q.cmp      <= simple_cmp;
    s1_q.res      <= simple_res;
    prod_q        <= prod_d;
  end

  // merge the multiply result into the side path
  always_comb begin
    side_d = s1_q;
    if (s1_q.kind == KIND_MUL) begin
      side_d.res = prod_q[FRAC_BITS +: DATA_W];
    end
  end

  // side path that keeps pace with the divider
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int k = 1; k < DIV_STEPS; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  assign last       = side_q[DIV_STEPS-1];
  assign quo_signed = quo_neg ? (~quo + 1'b1) : quo;

  // final select
  always_comb begin
    rsp_d.result         = last.res;
    rsp_d.compare_true   = last.cmp;
    rsp_d.divide_by_zero = 1'b0;
    if (last.kind == KIND_DIV) begin
      rsp_d.compare_true   = 1'b0;
      rsp_d.divide_by_zero = last.div_zero;
      rsp_d.result         = last.div_zero ? '0 : quo_signed[DATA_W-1:0];
    end
  end

  // valid tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      side_valid_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      s1_valid_q   <= in_valid_i;
      side_valid_q <= {side_valid_q[DIV_STEPS-2:0], s1_valid_q};
      valid_q      <= side_valid_q[DIV_STEPS-1];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

### rtl/core/fxalu_checker.sv
// ----------------------------------------------------------------------------
// fxalu_checker
// Port-level checks on the ALU core, attached by bind.
// ----------------------------------------------------------------------------
module fxalu_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  fxalu_pkg::alu_req_t req_i,
  input  logic                valid_o,
  input  fxalu_pkg::alu_rsp_t rsp_o
);
  import fxalu_pkg::*;

  // every accepted transaction yields a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##ALU_LATENCY valid_o)
    else $error("missing result strobe");

  // flags are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(rsp_o.compare_true && rsp_o.divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  // divide by zero gives zero and the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.op == OP_DIV && req_i.operand_b == '0
    |-> ##ALU_LATENCY rsp_o.divide_by_zero && rsp_o.result == '0)
    else $error("divide by zero result wrong");

  // add wraps to the data width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.op == OP_ADD
    |-> ##ALU_LATENCY rsp_o.result ==
        $past(req_i.operand_a + req_i.operand_b, ALU_LATENCY))
    else $error("add result wrong");

endmodule

bind fixed_point_q24_8_alu_core fxalu_checker u_checker (.*);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q24.8 fixed-point ALU. A short table of directed
// transactions, then 1100 random ones, is issued in bursts with random
// gaps. Every result is compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import fxalu_pkg::*;

  localparam int unsigned N_RANDOM    = 1100;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic signed [DATA_W-1:0] MAX_RAW = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] MIN_RAW = 32'sh80000000;

  // one directed transaction, with a hand-written result where it is obvious
  typedef struct packed {
    alu_req_t req;
    logic     has_exp;
    alu_rsp_t exp;
  } dir_row_t;

  localparam alu_rsp_t NO_EXP = '0;

  localparam dir_row_t DIRECTED [24] = '{
    '{'{OP_ADD,      32'sd0,    32'sd0},    1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_ADD,      MAX_RAW,   32'sd1},    1'b1, '{MIN_RAW, 1'b0, 1'b0}},
    '{'{OP_SUB,      MIN_RAW,   32'sd1},    1'b1, '{MAX_RAW, 1'b0, 1'b0}},
    '{'{OP_MUL,      MAX_RAW,   MAX_RAW},   1'b0, NO_EXP},
    '{'{OP_MUL,      MIN_RAW,   MIN_RAW},   1'b0, NO_EXP},
    '{'{OP_MUL,      -32'sd1,   32'sd1},    1'b0, NO_EXP},
    '{'{OP_DIV,      32'sd1,    32'sd0},    1'b1, '{32'sd0, 1'b0, 1'b1}},
    '{'{OP_DIV,      MIN_RAW,   32'sd0},    1'b1, '{32'sd0, 1'b0, 1'b1}},
    '{'{OP_DIV,      MIN_RAW,   -32'sd1},   1'b0, NO_EXP},
    '{'{OP_DIV,      -32'sd1,   32'sd3},    1'b0, NO_EXP},
    '{'{OP_INC,      MAX_RAW,   MIN_RAW},   1'b1, '{MIN_RAW, 1'b0, 1'b0}},
    '{'{OP_DEC,      MIN_RAW,   MAX_RAW},   1'b1, '{MAX_RAW, 1'b0, 1'b0}},
    '{'{OP_LT,       MIN_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_GT,       MIN_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_LE,       MAX_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_GE,       MIN_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_EQ,       MAX_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{'{OP_NE,       32'sd5,    32'sd5},    1'b1, '{32'sd0, 1'b0, 1'b0}},
    '{'{OP_MIN,      32'sd7,    32'sd7},    1'b0, NO_EXP},
    '{'{OP_MAX,      -32'sd3,   32'sd4},    1'b0, NO_EXP},
    '{'{OP_TO_INT,   -32'sd1,   32'sd0},    1'b1, '{-32'sd1, 1'b0, 1'b0}},
    '{'{OP_TO_INT,   MAX_RAW,   -32'sd1},   1'b0, NO_EXP},
    '{'{OP_FROM_INT, MAX_RAW,   32'sd9},    1'b1, '{32'shffffff00, 1'b0, 1'b0}},
    '{'{OP_FROM_INT, MIN_RAW,   MAX_RAW},   1'b1, '{32'sd0, 1'b0, 1'b0}}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  alu_req_t req_i;
  logic     valid_o;
  alu_rsp_t rsp_o;

  // hand-written result travelling alongside the request
  logic     fixed_valid;
  alu_rsp_t fixed_rsp;

  alu_rsp_t pending_rsp_q[$];
  int       n_fail;
  int       n_cycles;

  fixed_point_q24_8_alu_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // q24.8 arithmetic in 64 bits, wrapped to 32 on assignment
  function automatic alu_rsp_t fx_alu_result(input alu_req_t req);
    longint   a;
    longint   b;
    longint   wide;
    alu_rsp_t rsp;
    a    = longint'(req.operand_a);
    b    = longint'(req.operand_b);
    wide = 0;
    rsp  = '0;
    case (op_e'(req.op))
      OP_ADD:      wide = a + b;
      OP_SUB:      wide = a - b;
      OP_MUL:      wide = (a * b) >>> FRAC_BITS;
      OP_DIV: begin
        if (b == 0) rsp.divide_by_zero = 1'b1;
        else wide = (a <<< FRAC_BITS) / b;
      end
      OP_INC:      wide = a + 1;
      OP_DEC:      wide = a - 1;
      OP_LT:       rsp.compare_true = (a < b);
      OP_GT:       rsp.compare_true = (a > b);
      OP_LE:       rsp.compare_true = (a <= b);
      OP_GE:       rsp.compare_true = (a >= b);
      OP_EQ:       rsp.compare_true = (a == b);
      OP_NE:       rsp.compare_true = (a != b);
      OP_MIN:      wide = (a < b) ? a : b;
      OP_MAX:      wide = (a > b) ? a : b;
      OP_TO_INT:   wide = a >>> FRAC_BITS;
      OP_FROM_INT: wide = a << FRAC_BITS;
      default:     wide = 0;
    endcase
    rsp.result = wide[DATA_W-1:0];
    return rsp;
  endfunction

  // operand mix: corner values, small values around zero, full-range noise
  function automatic logic signed [DATA_W-1:0] rand_operand();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 32'sd0;
          1: v = 32'sd1;
          2: v = -32'sd1;
          3: v = MAX_RAW;
          4: v = MIN_RAW;
          5: v = 32'sd256;
          default: v = -32'sd256;
        endcase
      end
      1: v = $signed($urandom_range(0, 4095)) - 32'sd2048;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // compare outgoing results, then record each accepted transaction
  always @(posedge clk_i) begin : check_p
    alu_rsp_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result with no transaction pending: %h", rsp_o);
          n_fail++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_o.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, rsp_o.result);
            n_fail++;
          end
          if (rsp_o.compare_true !== want.compare_true) begin
            $error("compare_true: expected %0b, got %0b",
                   want.compare_true, rsp_o.compare_true);
            n_fail++;
          end
          if (rsp_o.divide_by_zero !== want.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, got %0b",
                   want.divide_by_zero, rsp_o.divide_by_zero);
            n_fail++;
          end
        end
      end
      if (start_i && !busy_o)
        pending_rsp_q.push_back(fixed_valid ? fixed_rsp : fx_alu_result(req_i));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // issue one transaction and hold it until it is taken
  task automatic send_txn(input alu_req_t req, input logic has_exp,
                          input alu_rsp_t exp);
    start_i     <= 1'b1;
    req_i       <= req;
    fixed_valid <= has_exp;
    fixed_rsp   <= exp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop issuing until every result is back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  // stimulus
  initial begin
    alu_req_t req;
    int       burst_left;
    n_fail      = 0;
    n_cycles    = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    fixed_valid = 1'b0;
    fixed_rsp   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[i]) begin
      send_txn(DIRECTED[i].req, DIRECTED[i].has_exp, DIRECTED[i].exp);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
    end
    drain_results();

    // random transactions in bursts
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      req.op        = 4'($urandom_range(0, 15));
      req.operand_a = rand_operand();
      req.operand_b = rand_operand();
      if ($urandom_range(0, 7) == 0) req.operand_b = req.operand_a;
      if (op_e'(req.op) == OP_DIV && $urandom_range(0, 9) == 0) req.operand_b = '0;
      send_txn(req, 1'b0, NO_EXP);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(5, 20));
        else idle_cycles($urandom_range(1, 4));
        burst_left = $urandom_range(1, 40);
      end
    end

    // wind down
    start_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (ALU_LATENCY + 4) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
